// File: rtl/wsl_pkg.sv
// Package of shared types and constants for the weighted span layout block.
package wsl_pkg;

    localparam int LEN_W = 16;
    localparam int GAP_W = 10;
    localparam int OFS_W = 23;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP   = 1'd1;

    typedef struct packed {
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] max_len;
        logic [LEN_W-1:0] pref_len;
        logic [LEN_W-1:0] grow_weight;
        logic             is_final;
    } t_item;

    typedef struct packed {
        logic [LEN_W-1:0] out_len;
        logic [OFS_W-1:0] out_offset;
        logic             end_of_group;
    } t_result;

endpackage

// File: rtl/wsl_ram.sv
// Generic single-port RAM with a registered read.
module wsl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: rtl/wsl_div.sv
// Serial restoring divider: one quotient bit per cycle, magnitudes only.
module wsl_div #(
    parameter int NW = 40,
    parameter int DW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW+1:0] w_diff;

    // Shift in the next numerator bit and try a subtract.
    assign w_trial = {r_rem[DW-1:0], r_quo[NW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/weighted_span_layout.sv
// Top level of the weighted span layout block: item store, totals and sequencer.
//
// Usage: configuration registers (available size, gap) are written on the plain
// write port while the block is idle. Items are sent with start while busy
// is low; each item is accepted, and stored while the store is not yet full.
// When the item marked final is accepted, busy rises and the group is resolved
// one item at a time: a store read, a multiply of free space by the weight in a
// shared multiplier, a divider start state, then a serial divide by the total
// weight at one quotient bit per cycle (51 bits with the default store depth)
// until done, then a clamp. Items with a zero weight, or any item when free
// space is not spread, skip the divide. Each stored item gives one result on
// o_result, marked by o_valid for exactly one cycle, in the cycle after its
// output state; the receiver cannot stall. Resolving starts with the free
// space state.
// Reset clears the totals, the count and the sequencer; the store needs no
// clearing, since only entries written in the current group are read.
module weighted_span_layout #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  wsl_pkg::t_item                i_item,
    output logic                          o_valid,
    output wsl_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [wsl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wsl_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNW = $clog2(MAX_ITEMS + 1);
    localparam int TW  = wsl_pkg::LEN_W + CNW;          // totals width
    localparam int FW  = TW + wsl_pkg::GAP_W + 2;       // signed free space width
    localparam int PW  = FW + wsl_pkg::LEN_W;           // product width, signed
    localparam int SW  = PW + 1;                        // signed size work width

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_FREE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;
    localparam logic [2:0] ST_DSTART = 3'd6;

    logic [wsl_pkg::LEN_W-1:0] r_avail;
    logic [wsl_pkg::GAP_W-1:0] r_gap;
    logic [TW-1:0]             r_pref_tot;
    logic [TW-1:0]             r_wt_tot;
    logic [CNW-1:0]            r_count;
    logic [2:0]                r_state;
    logic [AW-1:0]             r_idx;
    logic signed [FW-1:0]      r_free;
    logic                      r_spread;
    logic [wsl_pkg::OFS_W-1:0] r_pos;
    logic [PW-1:0]             r_prod_mag;
    logic                      r_neg;
    logic                      r_valid;
    wsl_pkg::t_result          r_result;

    logic                      w_acc;
    logic                      w_store;
    logic                      w_we;
    logic [AW-1:0]             w_addr;
    logic [63:0]               w_rdata;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [PW-1:0]             w_quo;
    logic signed [PW-1:0]      w_prod;
    logic [wsl_pkg::LEN_W-1:0] w_mn, w_mx, w_pf, w_wt;
    logic signed [SW-1:0]      w_size;
    logic [wsl_pkg::LEN_W-1:0] w_len;
    logic                      w_last;

    assign w_acc   = start && !busy;
    assign w_store = w_acc && (r_count < CNW'(MAX_ITEMS));
    assign w_we    = w_store;
    assign w_addr  = (r_state == ST_LOAD) ? r_count[AW-1:0] : r_idx;

    wsl_ram #(.WIDTH(64), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata ({i_item.grow_weight, i_item.pref_len, i_item.max_len, i_item.min_len}),
        .o_rdata (w_rdata)
    );

    assign w_mn = w_rdata[15:0];
    assign w_mx = w_rdata[31:16];
    assign w_pf = w_rdata[47:32];
    assign w_wt = w_rdata[63:48];

    // Shared multiplier: free space times the item weight.
    assign w_prod = PW'(r_free) * $signed({1'b0, w_wt});

    wsl_div #(.NW(PW), .DW(TW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod_mag),
        .i_den   (r_wt_tot),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // The divider starts once the product magnitude sits in its register.
    assign w_div_start = (r_state == ST_DSTART);

    // Grown size with the quotient's sign restored, then clamped.
    always_comb begin
        logic signed [SW-1:0] q;
        q = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        w_size = $signed(SW'(w_pf)) + q;
        if (w_size < $signed(SW'(w_mn))) begin
            w_size = SW'(w_mn);
        end else if (w_mx != '0 && w_size > $signed(SW'(w_mx))) begin
            w_size = SW'(w_mx);
        end
        if (w_size > $signed(SW'(17'h0FFFF))) begin
            w_size = SW'(17'h0FFFF);
        end
        w_len = w_size[wsl_pkg::LEN_W-1:0];
    end

    assign w_last = (CNW'(r_idx) + 1'b1) == r_count;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
            r_gap   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wsl_pkg::REG_AVAIL: r_avail <= i_cfg_data;
                wsl_pkg::REG_GAP:   r_gap   <= i_cfg_data[wsl_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: load items, compute free space, then resolve each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_pref_tot <= '0;
            r_wt_tot   <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_pref_tot <= r_pref_tot + TW'(i_item.pref_len);
                        r_wt_tot   <= r_wt_tot + TW'(i_item.grow_weight);
                        r_count    <= r_count + 1'b1;
                    end
                    if (w_acc && i_item.is_final) begin
                        r_state <= ST_FREE;
                    end
                end
                ST_FREE: begin
                    r_free <= $signed(FW'(r_avail)) - $signed(FW'(r_pref_tot))
                              - $signed(FW'(r_gap) * FW'(r_count - 1'b1));
                    r_idx  <= '0;
                    r_pos  <= '0;
                    if (r_count == '0) begin
                        r_state <= ST_LOAD;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_spread <= (r_free != '0) && (r_wt_tot != '0);
                    r_state  <= ST_MUL;
                end
                ST_MUL: begin
                    r_neg      <= w_prod[PW-1];
                    r_prod_mag <= w_prod[PW-1] ? PW'(-w_prod) : PW'(w_prod);
                    if (r_spread && (w_wt != '0)) begin
                        r_state <= ST_DSTART;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_DSTART: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_valid <= 1'b1;
                    r_result.out_len      <= (r_spread && w_wt != '0) ? w_len : w_pf;
                    r_result.out_offset   <= r_pos;
                    r_result.end_of_group <= w_last;
                    r_pos <= r_pos + wsl_pkg::OFS_W'((r_spread && w_wt != '0) ? w_len : w_pf)
                             + wsl_pkg::OFS_W'(r_gap);
                    r_idx <= r_idx + 1'b1;
                    if (w_last) begin
                        r_state    <= ST_LOAD;
                        r_pref_tot <= '0;
                        r_wt_tot   <= '0;
                        r_count    <= '0;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign busy     = (r_state != ST_LOAD);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The count never runs past the store depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= CNW'(MAX_ITEMS))
        else $error("item count above store depth");
    // A result only leaves from the output state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == ST_OUT)
        else $error("result without output state");
    // The last result of a group returns the block to loading with a cleared item count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.end_of_group) |-> (r_state == ST_LOAD && r_count == '0))
        else $error("group not closed after last result");
    // The divider only finishes while the sequencer waits on it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_div_done |-> r_state == ST_DIV)
        else $error("divider done outside divide state");

endmodule
